### design/mlm_pkg.sv
package mlm_pkg;

  localparam int ID_W       = 6;
  localparam int TASK_W     = 6;
  localparam int COUNT_W    = 8;
  localparam int CFG_W      = 6;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic MODE_LOCK       = 1'b0;
  localparam logic MODE_UNLOCK     = 1'b1;
  localparam logic REG_MUTEX_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_INVALID   = 3'd2,
    ST_DEADLOCK  = 3'd3,
    ST_NOT_OWNER = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LINK,
    S_POP
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   mutex_number;
    logic [TASK_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic               wake_valid;
    logic [TASK_W-1:0]  wake_task;
    logic [COUNT_W-1:0] caller_locks_held;
  } rsp_t;

endpackage

### design/mlm_regs.sv
module mlm_regs
  import mlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CFG_W-1:0]      mutex_count
);

  logic reg_sel;

  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_MUTEX_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(mutex_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mutex_count <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      mutex_count <= pwdata[CFG_W-1:0];
    end
  end

endmodule

### design/mutex_lock_manager_fifo_top.sv
// Channel  Signals                         Carries
// req      req_valid, req_ready, req       lock/unlock request beat
// rsp      rsp_valid, rsp_ready, rsp       one status beat per request
// apb      psel..pready                    mutex_count register at 0x0
//
// One request at a time: accept, table read, then the result.
// A queued lock and an unlock with a waiter pass through an extra state, S_LINK
// or S_POP, for a second link write or the wait for the head's link read.
// Reset clears the held/queue flags and lock counts through per-entry valid bits.
// A full rsp register stalls only the final state; no request is taken meanwhile.
module mutex_lock_manager_fifo_top
  import mlm_pkg::*;
#(
  parameter int NUM_MUTEXES = 32,
  parameter int NUM_TASKS   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam logic [TW:0] LINK_END = {1'b1, {TW{1'b0}}};

  typedef struct packed {
    logic          held;
    logic [TW-1:0] holder;
    logic          qne;
    logic [TW-1:0] head;
    logic [TW-1:0] tail;
  } mtx_t;

  logic [CFG_W-1:0] mutex_count;

  mlm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mutex_count (mutex_count)
  );

  state_t state, state_next;

  logic          r_mode;
  logic [TW-1:0] r_tidx;
  logic [MW-1:0] r_midx;
  logic          r_task_ok;
  logic          r_id_ok;

  logic [8:0] lim;
  logic       acc;

  mtx_t             mtx_mem [NUM_MUTEXES];
  logic [NUM_MUTEXES-1:0] mvalid;
  mtx_t             mtx_rd;
  logic             mtx_rd_valid;
  logic             mtx_re;
  logic [MW-1:0]    mtx_ra;
  logic             mtx_we;
  mtx_t             mtx_wd;
  mtx_t             mtx_cur;

  logic [COUNT_W-1:0] cnt_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] cvalid;
  logic [COUNT_W-1:0] cnt_rd;
  logic               cnt_rd_valid;
  logic               cnt_re;
  logic [TW-1:0]      cnt_ra;
  logic               cnt_we;
  logic [TW-1:0]      cnt_wa;
  logic [COUNT_W-1:0] cnt_wd;
  logic [COUNT_W-1:0] cnt_cur;

  logic [TW:0]   lnk_mem [NUM_TASKS];
  logic [TW:0]   lnk_rd;
  logic          lnk_re;
  logic [TW-1:0] lnk_ra;
  logic          lnk_we;
  logic [TW-1:0] lnk_wa;
  logic [TW:0]   lnk_wd;

  logic [COUNT_W-1:0] dec_cnt, dec_cnt_next;
  logic [COUNT_W-1:0] cnt_inc, cnt_dec, head_cnt, head_inc;
  logic               head_is_caller;
  logic               out_free;
  logic               emit;
  rsp_t               res;

  assign lim = ({3'b0, mutex_count} > 9'(NUM_MUTEXES)) ? 9'(NUM_MUTEXES)
                                                       : {3'b0, mutex_count};
  assign req_ready = (state == S_IDLE) && !rst;
  assign acc       = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      r_mode    <= req.mode;
      r_tidx    <= TW'(req.task_id);
      r_midx    <= MW'(req.mutex_number - 6'd1);
      r_task_ok <= ({3'b0, req.task_id} < 9'(NUM_TASKS));
      r_id_ok   <= (req.mutex_number != '0) && ({3'b0, req.mutex_number} <= lim);
    end
    dec_cnt <= dec_cnt_next;
  end

  // mutex table
  always_ff @(posedge clk) begin
    if (mtx_we) begin
      mtx_mem[r_midx] <= mtx_wd;
    end
    if (mtx_re) begin
      mtx_rd <= mtx_mem[mtx_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid       <= '0;
      mtx_rd_valid <= 1'b0;
    end else begin
      if (mtx_re) begin
        mtx_rd_valid <= mvalid[mtx_ra];
      end
      if (mtx_we) begin
        mvalid[r_midx] <= 1'b1;
      end
    end
  end

  // lock count table
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd <= cnt_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid       <= '0;
      cnt_rd_valid <= 1'b0;
    end else begin
      if (cnt_re) begin
        cnt_rd_valid <= cvalid[cnt_ra];
      end
      if (cnt_we) begin
        cvalid[cnt_wa] <= 1'b1;
      end
    end
  end

  // wait queue links
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_wa] <= lnk_wd;
    end
    if (lnk_re) begin
      lnk_rd <= lnk_mem[lnk_ra];
    end
  end

  always_comb begin
    mtx_cur        = mtx_rd;
    mtx_cur.held   = mtx_rd_valid && mtx_rd.held;
    mtx_cur.holder = mtx_rd_valid ? mtx_rd.holder : '0;
    mtx_cur.qne    = mtx_rd_valid && mtx_rd.qne;
    cnt_cur        = cnt_rd_valid ? cnt_rd : '0;
    cnt_inc        = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);
    cnt_dec        = (cnt_cur == '0) ? cnt_cur : cnt_cur - COUNT_W'(1);
    head_is_caller = (mtx_cur.head == r_tidx);
    head_cnt       = head_is_caller ? dec_cnt : cnt_cur;
    head_inc       = (head_cnt == '1) ? head_cnt : head_cnt + COUNT_W'(1);
  end

  always_comb begin
    state_next   = state;
    dec_cnt_next = dec_cnt;
    mtx_re = 1'b0;
    mtx_ra = MW'(req.mutex_number - 6'd1);
    mtx_we = 1'b0;
    mtx_wd = mtx_cur;
    cnt_re = 1'b0;
    cnt_ra = TW'(req.task_id);
    cnt_we = 1'b0;
    cnt_wa = r_tidx;
    cnt_wd = cnt_inc;
    lnk_re = 1'b0;
    lnk_ra = mtx_cur.head;
    lnk_we = 1'b0;
    lnk_wa = r_tidx;
    lnk_wd = LINK_END;
    emit   = 1'b0;
    res.status            = ST_DONE;
    res.wake_valid        = 1'b0;
    res.wake_task         = '0;
    res.caller_locks_held = cnt_cur;

    case (state)
      S_IDLE: begin
        if (acc) begin
          mtx_re     = 1'b1;
          cnt_re     = 1'b1;
          state_next = S_READ;
        end
      end

      S_READ: begin
        if (!r_task_ok || !r_id_ok) begin
          res.status            = ST_INVALID;
          res.caller_locks_held = r_task_ok ? cnt_cur : '0;
          emit                  = out_free;
        end else if (r_mode == MODE_LOCK) begin
          if (!mtx_cur.held) begin
            res.caller_locks_held = cnt_inc;
            emit                  = out_free;
            mtx_we                = out_free;
            mtx_wd.held           = 1'b1;
            mtx_wd.holder         = r_tidx;
            cnt_we                = out_free;
          end else if (mtx_cur.holder == r_tidx) begin
            res.status = ST_DEADLOCK;
            emit       = out_free;
          end else begin
            mtx_we      = 1'b1;
            mtx_wd.qne  = 1'b1;
            mtx_wd.head = mtx_cur.qne ? mtx_cur.head : r_tidx;
            mtx_wd.tail = r_tidx;
            lnk_we      = mtx_cur.qne;
            lnk_wa      = mtx_cur.tail;
            lnk_wd      = {1'b0, r_tidx};
            state_next  = S_LINK;
          end
        end else begin
          if (!mtx_cur.held || mtx_cur.holder != r_tidx) begin
            res.status = ST_NOT_OWNER;
            emit       = out_free;
          end else if (!mtx_cur.qne) begin
            res.caller_locks_held = cnt_dec;
            emit                  = out_free;
            mtx_we                = out_free;
            mtx_wd.held           = 1'b0;
            mtx_wd.holder         = '0;
            cnt_we                = out_free;
            cnt_wd                = cnt_dec;
          end else begin
            cnt_we       = 1'b1;
            cnt_wd       = cnt_dec;
            dec_cnt_next = cnt_dec;
            cnt_re       = 1'b1;
            cnt_ra       = mtx_cur.head;
            lnk_re       = 1'b1;
            state_next   = S_POP;
          end
        end
        if (emit) begin
          state_next = S_IDLE;
        end
      end

      S_LINK: begin
        res.status = ST_QUEUED;
        emit       = out_free;
        lnk_we     = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      S_POP: begin
        res.wake_valid        = 1'b1;
        res.wake_task         = TASK_W'(mtx_cur.head);
        res.caller_locks_held = head_is_caller ? head_inc : dec_cnt;
        emit                  = out_free;
        cnt_we                = out_free;
        cnt_wa                = mtx_cur.head;
        cnt_wd                = head_inc;
        lnk_we                = out_free;
        lnk_wa                = mtx_cur.head;
        mtx_we                = out_free;
        mtx_wd.held           = 1'b1;
        mtx_wd.holder         = mtx_cur.head;
        mtx_wd.qne            = !lnk_rd[TW];
        mtx_wd.head           = lnk_rd[TW] ? mtx_cur.head : lnk_rd[TW-1:0];
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= res;
    end
  end

endmodule

### tb/tb_mutex_lock_manager_fifo_top.sv
module tb_mutex_lock_manager_fifo_top;
  import mlm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_MUTEXES = 32;
  localparam int NUM_TASKS = 64;
  localparam logic [6:0] LINK_END = 7'h7f;
  localparam logic [APB_ADDR_W-1:0] ADDR_MUTEX_COUNT =
    APB_ADDR_W'(4 * int'(REG_MUTEX_COUNT));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  mutex_lock_manager_fifo_top #(
    .NUM_MUTEXES(NUM_MUTEXES),
    .NUM_TASKS(NUM_TASKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // lock table mirror
  logic [CFG_W-1:0] cfg_count = '0;
  logic held[NUM_MUTEXES];
  logic [TASK_W-1:0] owner[NUM_MUTEXES];
  logic waiters[NUM_MUTEXES];
  logic [TASK_W-1:0] wait_head[NUM_MUTEXES];
  logic [TASK_W-1:0] wait_tail[NUM_MUTEXES];
  logic [6:0] wait_link[NUM_TASKS];
  logic [COUNT_W-1:0] locks_held[NUM_TASKS];

  req_t lock_requests[$];
  rsp_t outcomes[$];
  int requests_queued = 0;
  int outcomes_seen = 0;
  int mismatches = 0;
  logic calm = 1'b0;
  logic hold_rsp = 1'b0;

  initial begin
    for (int i = 0; i < NUM_MUTEXES; i++) begin
      held[i] = 1'b0;
      owner[i] = '0;
      waiters[i] = 1'b0;
      wait_head[i] = '0;
      wait_tail[i] = '0;
    end
    for (int i = 0; i < NUM_TASKS; i++) begin
      wait_link[i] = '0;
      locks_held[i] = '0;
    end
  end

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic rsp_t arbitrate(req_t r);
    rsp_t o;
    int lim;
    int m;
    logic [TASK_W-1:0] t;
    logic [TASK_W-1:0] h;
    logic [6:0] nx;
    o = '{status: ST_DONE, wake_valid: 1'b0, wake_task: '0, caller_locks_held: '0};
    t = r.task_id;
    lim = (int'(cfg_count) > NUM_MUTEXES) ? NUM_MUTEXES : int'(cfg_count);
    if (r.mutex_number == 0 || int'(r.mutex_number) > lim) begin
      o.status = ST_INVALID;
      o.caller_locks_held = locks_held[t];
      return o;
    end
    m = int'(r.mutex_number) - 1;
    if (r.mode == MODE_LOCK) begin
      if (!held[m]) begin
        held[m] = 1'b1;
        owner[m] = t;
        if (locks_held[t] != 8'hff) locks_held[t]++;
      end else if (owner[m] == t) begin
        o.status = ST_DEADLOCK;
      end else begin
        if (!waiters[m]) begin
          wait_head[m] = t;
          waiters[m] = 1'b1;
        end else begin
          wait_link[wait_tail[m]] = {1'b0, t};
        end
        wait_tail[m] = t;
        wait_link[t] = LINK_END;
        o.status = ST_QUEUED;
      end
    end else begin
      if (!held[m] || owner[m] != t) begin
        o.status = ST_NOT_OWNER;
      end else begin
        if (locks_held[t] != 0) locks_held[t]--;
        if (!waiters[m]) begin
          held[m] = 1'b0;
          owner[m] = '0;
        end else begin
          h = wait_head[m];
          nx = wait_link[h];
          owner[m] = h;
          if (locks_held[h] != 8'hff) locks_held[h]++;
          wait_link[h] = LINK_END;
          if (nx != LINK_END) wait_head[m] = nx[TASK_W-1:0];
          else waiters[m] = 1'b0;
          o.wake_valid = 1'b1;
          o.wake_task = h;
        end
      end
    end
    o.caller_locks_held = locks_held[t];
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) outcomes.push_back(arbitrate(req));
      if (!req_valid || req_ready) begin
        if (lock_requests.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
          req <= lock_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !hold_rsp && (calm || $urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      outcomes_seen++;
      if (outcomes.size() == 0) begin
        if (mismatches < 10) $display("unexpected beat: %p", rsp);
        mismatches++;
      end else begin
        want = outcomes.pop_front();
        if (rsp.status !== want.status || rsp.wake_valid !== want.wake_valid ||
            rsp.wake_task !== want.wake_task ||
            rsp.caller_locks_held !== want.caller_locks_held) begin
          if (mismatches < 10) begin
            $display("mismatch: expected %s wake %0b/%0d held %0d, got %s wake %0b/%0d held %0d",
                     want.status.name(), want.wake_valid, want.wake_task,
                     want.caller_locks_held, rsp.status.name(), rsp.wake_valid,
                     rsp.wake_task, rsp.caller_locks_held);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic write_count(input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MUTEX_COUNT;
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_count = CFG_W'(value);
  endtask

  task automatic send(input logic mode, input int id, input int tsk);
    req_t r;
    r.mode = mode;
    r.mutex_number = ID_W'(id);
    r.task_id = TASK_W'(tsk);
    lock_requests.push_back(r);
    requests_queued++;
  endtask

  task automatic drain();
    wait (outcomes_seen >= requests_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_random(input int n);
    int lim;
    int span;
    int mbase;
    int tbase;
    int id;
    int tsk;
    lim = (int'(cfg_count) > NUM_MUTEXES) ? NUM_MUTEXES : int'(cfg_count);
    span = (lim < 4) ? lim : 4;
    mbase = (lim > 0) ? $urandom_range(lim - span + 1, 1) : 1;
    tbase = $urandom_range(60, 0);
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      if (lim == 0 || $urandom_range(99) < 15) id = $urandom_range(63, 0);
      else id = mbase + $urandom_range(span - 1, 0);
      if ($urandom_range(99) < 15) tsk = $urandom_range(63, 0);
      else tsk = tbase + $urandom_range(3, 0);
      send(($urandom_range(99) < 55) ? MODE_LOCK : MODE_UNLOCK, id, tsk);
    end
  endtask

  task automatic random_phase(input int count, input int n);
    write_count(count);
    push_random(n);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    @(negedge clk);
    send(MODE_LOCK, 1, 5);
    send(MODE_UNLOCK, 0, 0);
    drain();

    write_count(32);
    @(negedge clk);
    send(MODE_LOCK, 0, 1);
    send(MODE_LOCK, 33, 1);
    send(MODE_LOCK, 63, 63);
    send(MODE_LOCK, 32, 63);
    send(MODE_LOCK, 1, 1);
    send(MODE_LOCK, 1, 1);
    send(MODE_LOCK, 1, 2);
    send(MODE_LOCK, 1, 3);
    send(MODE_LOCK, 1, 2);
    send(MODE_UNLOCK, 1, 2);
    send(MODE_UNLOCK, 2, 0);
    send(MODE_UNLOCK, 1, 1);
    send(MODE_UNLOCK, 1, 2);
    send(MODE_UNLOCK, 1, 3);
    send(MODE_UNLOCK, 32, 63);
    send(MODE_LOCK, 5, 9);
    drain();

    random_phase(63, 115);
    random_phase(1, 110);
    random_phase(0, 60);
    random_phase(7, 115);
    random_phase($urandom_range(63, 0), 110);

    @(posedge clk);
    calm <= 1'b1;
    random_phase(32, 110);
    @(posedge clk);
    calm <= 1'b0;

    write_count(32);
    push_random(115);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (150) @(posedge clk);
    hold_rsp <= 1'b0;
    drain();

    random_phase(63, 197);

    repeat (10) @(posedge clk);
    if (outcomes.size() != 0) mismatches++;
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
design/mlm_pkg.sv
design/mlm_regs.sv
design/mutex_lock_manager_fifo_top.sv
tb/tb_mutex_lock_manager_fifo_top.sv
